/* design/scalar_kalman_three_axis_assert.svh */
// Assertion macros used by the checker file.
`ifndef SCALAR_KALMAN_THREE_AXIS_ASSERT_SVH
`define SCALAR_KALMAN_THREE_AXIS_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SKT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/skt_pkg.sv */
package skt_pkg;

  // Field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned EstW     = 24;  // signed Q16.8
  localparam int unsigned ErrW     = 32;  // unsigned Q24.8
  localparam int unsigned MeasW    = 24;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned GainW    = 16;  // unsigned Q0.16
  localparam int unsigned NumLanes = 3;

  // Config port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgMeasErr   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgProcNoise = CfgIdxW'(1);

  // Reset values
  localparam logic [MeasW-1:0]  MeasErrRst   = MeasW'(9800);
  localparam logic [NoiseW-1:0] ProcNoiseRst = NoiseW'(10);
  localparam logic [ErrW-1:0]   ErrRst       = ErrW'(9800 * 256);

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic signed [SampleW-1:0] sample_z;
  } skt_in_t;

  typedef struct packed {
    logic signed [EstW-1:0] filtered_x;
    logic signed [EstW-1:0] filtered_y;
    logic signed [EstW-1:0] filtered_z;
  } skt_out_t;

  // Lane status seen by the top level and the merge stage
  typedef struct packed {
    logic busy;
    logic done;
  } skt_lane_stat_t;

endpackage

/* design/skt_lane.sv */
module skt_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [skt_pkg::SampleW-1:0]  sample_i,
  input  logic [skt_pkg::MeasW-1:0]    meas_err_i,
  input  logic [skt_pkg::NoiseW-1:0]   noise_fac_i,
  output skt_pkg::skt_lane_stat_t      stat_o,
  output logic [skt_pkg::EstW-1:0]     est_o
);
  import skt_pkg::*;

  localparam int unsigned DivSteps = GainW + 1;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned DenW     = ErrW + 1;
  localparam int unsigned RemW     = ErrW + 2;
  localparam int unsigned MagW     = EstW + 1;
  localparam int unsigned P1W      = EstW + GainW;
  localparam int unsigned P2W      = ErrW + GainW;
  localparam int unsigned P3W      = EstW + NoiseW;
  localparam int unsigned SumW     = P3W + 1;

  typedef enum logic [4:0] {
    LIdle = 5'b00001,
    LDiv  = 5'b00010,
    LMul  = 5'b00100,
    LUpd  = 5'b01000,
    LErr  = 5'b10000
  } skt_lane_state_e;

  skt_lane_state_e state_q, state_d;

  logic [EstW-1:0] est_q, est_d;
  logic [ErrW-1:0] err_q, err_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] den_q, den_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [GainW:0]  quo_q, quo_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic            neg_q, neg_d;
  logic [P1W-1:0]  p1_q, p1_d;
  logic [P2W-1:0]  p2_q, p2_d;
  logic [P3W-1:0]  p3_q, p3_d;

  logic [MagW-1:0] innov;
  logic [RemW-1:0] den_ext, rem_sub;
  logic            ge;
  logic [GainW-1:0] gain;
  logic [EstW-1:0] dmag;
  logic [SumW-1:0] err_sum;

  // Innovation (sample minus estimate); sign and magnitude are taken at start while the estimate is settled
  assign innov = {sample_i[SampleW-1], sample_i, 8'b0} - {est_q[EstW-1], est_q};

  // One restoring divide step: compare, subtract, shift
  assign den_ext = {1'b0, den_q};
  assign ge      = (rem_q >= den_ext);
  assign rem_sub = ge ? (rem_q - den_ext) : rem_q;

  // Gain from the quotient: zero divisor gives 0, exact one clips to max
  always_comb begin
    if (den_q == '0) begin
      gain = '0;
    end else if (quo_q[GainW]) begin
      gain = '1;
    end else begin
      gain = quo_q[GainW-1:0];
    end
  end

  assign dmag    = p1_q[P1W-1:GainW];
  assign err_sum = SumW'(p2_q[P2W-1:GainW]) + SumW'(p3_q);

  always_comb begin
    state_d = state_q;
    est_d   = est_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    p3_d    = p3_q;
    case (state_q)
      LIdle: begin
        if (start_i) begin
          den_d   = DenW'(err_q) + DenW'({meas_err_i, 8'b0});
          rem_d   = RemW'(err_q);
          cnt_d   = '0;
          neg_d   = innov[MagW-1];
          mag_d   = innov[MagW-1] ? (~innov + MagW'(1)) : innov;
          state_d = LDiv;
        end
      end
      LDiv: begin
        quo_d = {quo_q[GainW-1:0], ge};
        rem_d = {rem_sub[RemW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = LMul;
        end
      end
      LMul: begin
        p1_d    = P1W'(mag_q) * P1W'(gain);
        p2_d    = P2W'(({1'b0, {GainW{1'b0}}} | (GainW+1)'(1 << GainW)) - (GainW+1)'(gain))
                  * P2W'(err_q);
        state_d = LUpd;
      end
      LUpd: begin
        est_d   = neg_q ? (est_q - dmag) : (est_q + dmag);
        p3_d    = P3W'(dmag) * P3W'(noise_fac_i);
        state_d = LErr;
      end
      LErr: begin
        err_d   = (|err_sum[SumW-1:ErrW]) ? '1 : err_sum[ErrW-1:0];
        state_d = LIdle;
      end
      default: begin
        state_d = LIdle;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LIdle;
      est_q   <= '0;
      err_q   <= ErrRst;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      err_q   <= err_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    p3_q  <= p3_d;
  end

  assign stat_o.busy = (state_q != LIdle);
  assign stat_o.done = (state_q == LErr);
  assign est_o       = est_q;

endmodule

/* design/skt_merge.sv */
module skt_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  skt_pkg::skt_lane_stat_t   stat_i [skt_pkg::NumLanes],
  input  logic [skt_pkg::EstW-1:0]  est_i  [skt_pkg::NumLanes],
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output skt_pkg::skt_out_t         out_data_o,
  output logic                      pend_o
);
  import skt_pkg::*;

  logic     all_done, avail, load;
  logic     valid_q, valid_d;
  logic     pend_q, pend_d;
  skt_out_t data_q;

  // Lanes run in lockstep; gather once all of them finish
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NumLanes; i++) begin
      all_done = all_done & stat_i[i].done;
    end
  end

  // Hold the lanes' result while the output beat is still waiting
  assign avail   = all_done | pend_q;
  assign load    = avail & (~valid_q | out_ready_i);
  assign pend_d  = avail & ~load;
  assign valid_d = load | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q.filtered_x <= est_i[0];
      data_q.filtered_y <= est_i[1];
      data_q.filtered_z <= est_i[2];
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign pend_o      = pend_q;

endmodule

/* design/scalar_kalman_three_axis.sv */
// Three-axis scalar Kalman filter for raw accelerometer samples.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat carries a signed
// 16-bit sample per axis. Output channel (out_valid_o/out_ready_i/out_data_o):
// one beat per input beat with the new signed Q16.8 estimate of each axis.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): index 0 is
// measurement_error, index 1 is process noise; other indexes are ignored.
// Write config only while no beat is in flight.
// Each axis has its own lane; a lane runs a one-bit-per-cycle restoring divider
// for the gain, then the multiply, estimate update and error update steps. A new
// beat is taken only once all lanes have finished the previous one.
// The output register lets the next beat enter while a result waits; if the
// receiver still stalls when the next result is done, that result is held
// and in_ready_o stays low until it moves to the output register.
// Reset: estimates clear to zero, error estimates to 9800 in Q24.8, config
// registers to their defaults; no output beat is pending.
module scalar_kalman_three_axis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  skt_pkg::skt_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output skt_pkg::skt_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [skt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [skt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import skt_pkg::*;

  logic [MeasW-1:0]   meas_q;
  logic [NoiseW-1:0]  noise_q;
  logic               start;
  logic               busy;
  logic               pend;
  logic [SampleW-1:0] samples [NumLanes];
  logic [EstW-1:0]    ests    [NumLanes];
  skt_lane_stat_t     stats   [NumLanes];

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q  <= MeasErrRst;
      noise_q <= ProcNoiseRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMeasErr:   meas_q  <= cfg_data_i[MeasW-1:0];
        CfgProcNoise: noise_q <= cfg_data_i[NoiseW-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      busy = busy | stats[i].busy;
    end
  end

  assign in_ready_o = ~busy & ~pend;
  assign start      = in_valid_i & in_ready_o;

  assign samples[0] = in_data_i.sample_x;
  assign samples[1] = in_data_i.sample_y;
  assign samples[2] = in_data_i.sample_z;

  // One filter lane per axis
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    skt_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .start_i      (start),
      .sample_i     (samples[g]),
      .meas_err_i   (meas_q),
      .noise_fac_i  (noise_q),
      .stat_o       (stats[g]),
      .est_o        (ests[g])
    );
  end

  // Gather lane results into the output beat
  skt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stats),
    .est_i       (ests),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .pend_o      (pend)
  );

endmodule

/* design/skt_checker.sv */
`include "scalar_kalman_three_axis_assert.svh"

module skt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input skt_pkg::skt_in_t              in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input skt_pkg::skt_out_t             out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [skt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [skt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import skt_pkg::*;

  // A stalled output beat keeps its valid and data
  `SKT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output beat dropped or changed while stalled")

  // An accepted beat keeps the block busy in the next cycle
  `SKT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input taken while a beat is in flight")

  // No result can appear right after an input beat
  `SKT_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_o, !$rose(out_valid_o), "result appeared one cycle after accept")

  // A fresh result frees the input side
  `SKT_ASSERT_SAME(a_ready_on_result, $rose(out_valid_o), in_ready_o, "input not ready after result was loaded")

endmodule

bind scalar_kalman_three_axis skt_checker u_skt_checker (.*);
